/* hdl/resource_usage_alert_monitor_defines.svh */
// assertion macros for the resource usage alert monitor
`ifndef RESOURCE_USAGE_ALERT_MONITOR_DEFINES_SVH
`define RESOURCE_USAGE_ALERT_MONITOR_DEFINES_SVH

`ifndef SYNTHESIS
// checked property, switched off while reset is asserted
`define RUAM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked property that also holds through reset
`define RUAM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RUAM_ASSERT(lbl, clk, rst_n, prop, msg)
`define RUAM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* hdl/ruam_pkg.sv */
// types, constants and codes shared by the resource usage alert monitor
package ruam_pkg;

    localparam int MEM_W     = 48;
    localparam int CPU_W     = 15;
    localparam int HND_W     = 16;
    localparam int LIMIT_W   = 49;
    localparam int TOTAL_W   = 32;
    localparam int HELD_W    = 8;
    localparam int LEAK_W    = 53;
    localparam int CFG_DATA_W = 48;

    localparam int WINDOW_DEPTH_DEF = 128;

    localparam logic [CPU_W-1:0]   CPU_MAX          = 15'd25600;
    localparam logic [MEM_W-1:0]   MEM_MIN_LIMIT    = 48'd1048576;
    localparam logic [HND_W-1:0]   HND_MIN_LIMIT    = 16'd10;
    localparam logic [MEM_W-1:0]   MEM_LIMIT_RST    = 48'd536870912;
    localparam logic [HND_W-1:0]   HND_LIMIT_RST    = 16'd256;
    localparam int                 LEAK_MIN_HELD    = 5;
    localparam int                 LEAK_DEN         = 20;

    localparam logic [0:0] CFG_MEM_LIMIT = 1'b0;
    localparam logic [0:0] CFG_HND_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_LEAK    = 2'd1,
        KIND_MEM     = 2'd2,
        KIND_HANDLES = 2'd3
    } t_alert_kind;

    typedef enum logic [1:0] {
        DIV_MEM  = 2'd0,
        DIV_CPU  = 2'd1,
        DIV_LEAK = 2'd2
    } t_div_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPDATE,
        S_CHECK,
        S_START_MEM,
        S_WAIT_MEM,
        S_START_CPU,
        S_WAIT_CPU,
        S_START_LEAK,
        S_WAIT_LEAK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [MEM_W-1:0] mem_used;
        logic [CPU_W-1:0] cpu_load;
        logic [HND_W-1:0] handles_open;
    } t_in_item;

    typedef struct packed {
        t_alert_kind        alert_kind;
        logic [MEM_W-1:0]   alert_value;
        logic [LIMIT_W-1:0] alert_limit;
        logic [TOTAL_W-1:0] alert_total;
        logic [MEM_W-1:0]   peak_mem;
        logic [CPU_W-1:0]   peak_cpu;
        logic [HND_W-1:0]   peak_handles;
        logic [HELD_W-1:0]  samples_held;
        logic [MEM_W-1:0]   mean_mem;
        logic [CPU_W-1:0]   mean_cpu;
    } t_out_item;

    typedef struct packed {
        logic     latch;
        logic     update;
        logic     check;
        logic     div_start;
        t_div_sel div_sel;
        logic     emit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic need_leak;
        logic out_free;
    } t_sts;

endpackage

/* hdl/ruam_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
module ruam_div import ruam_pkg::*; #(
    parameter int NW  = 56,
    parameter int DVW = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [NW-1:0]  i_dividend,
    input  logic [DVW-1:0] i_divisor,
    output logic           o_done,
    output logic [NW-1:0]  o_quotient
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [NW-1:0]    r_quo, n_quo;
    logic [DVW-1:0]   r_rem, n_rem;
    logic [DVW-1:0]   r_dvs, n_dvs;
    logic [DVW:0]     rem_sh;
    logic             ge;

    always_comb begin
        rem_sh = {r_rem, r_quo[NW-1]};
        ge     = rem_sh >= {1'b0, r_dvs};
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_done = 1'b0;
        if (i_start) begin
            n_cnt = CNT_W'(NW);
            n_quo = i_dividend;
            n_rem = '0;
            n_dvs = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt  = r_cnt - 1'b1;
            n_quo  = {r_quo[NW-2:0], ge};
            n_rem  = ge ? DVW'(rem_sh - {1'b0, r_dvs}) : DVW'(rem_sh);
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* hdl/ruam_datapath.sv */
// window memory, sums, peaks, alert checks, averages and result register
module ruam_datapath import ruam_pkg::*; #(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  t_in_item              i_in_item,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item
);

    localparam int PW   = $clog2(WINDOW_DEPTH);
    localparam int CW   = $clog2(WINDOW_DEPTH + 1);
    localparam int SW   = MEM_W + CW;
    localparam int CSW  = CPU_W + CW;
    localparam int NW   = SW;
    localparam int DVW  = CW;
    localparam int EW   = MEM_W + CPU_W;

    // reciprocal of five, exact for a 19-bit partial dividend
    localparam logic [18:0] RECIP5 = 19'd419431;

    // window store
    logic [EW-1:0] r_win [WINDOW_DEPTH];
    logic [EW-1:0] r_rd_data;
    logic          mem_we, mem_re;
    logic [PW-1:0] rd_addr;

    logic [MEM_W-1:0]   r_mem;
    logic [CPU_W-1:0]   r_cpu;
    logic [HND_W-1:0]   r_hnd;
    logic [PW-1:0]      r_wp, n_wp;
    logic [CW-1:0]      r_held, n_held;
    logic [SW-1:0]      r_mem_sum;
    logic [CSW-1:0]     r_cpu_sum;
    logic [MEM_W-1:0]   r_peak_mem;
    logic [CPU_W-1:0]   r_peak_cpu;
    logic [HND_W-1:0]   r_peak_hnd;
    t_alert_kind        r_kind;
    logic [MEM_W-1:0]   r_aval;
    logic [LIMIT_W-1:0] r_alim;
    logic [TOTAL_W-1:0] r_total;
    logic [MEM_W-1:0]   r_mem_lim;
    logic [HND_W-1:0]   r_hnd_lim;
    logic [LEAK_W-1:0]  r_leak_prod;
    logic               r_need_leak;
    logic [MEM_W-1:0]   r_mean_mem;
    logic [CPU_W-1:0]   r_mean_cpu;
    t_div_sel           r_div_sel;
    t_out_item          r_out;
    logic               r_out_valid;

    // divide by twenty for the leak limit, sixteen bits a cycle
    logic [2:0]         r_c5_cnt;
    logic               r_c5_done;
    logic [63:0]        r_c5_num;
    logic [63:0]        r_c5_quo;
    logic [2:0]         r_c5_rem;
    logic [18:0]        c5_part;
    logic [37:0]        c5_prod;
    logic [15:0]        c5_digit;
    logic [2:0]         c5_rem;
    logic               c5_start;

    logic               full;
    logic [CPU_W-1:0]   cpu_clamped;
    logic [MEM_W-1:0]   old_mem;
    logic [CPU_W-1:0]   old_cpu;
    logic [LEAK_W-1:0]  new_x20, old_x21;
    logic               leak_hit, mem_hit, hnd_hit;
    logic [1:0]         hits;
    logic [TOTAL_W:0]   total_sum;
    logic [NW-1:0]      div_dividend;
    logic [DVW-1:0]     div_divisor;
    logic               bdiv_start;
    logic               bdiv_done;
    logic               div_done;
    logic [NW-1:0]      div_quo;
    logic               out_take;

    assign full        = (r_held == CW'(WINDOW_DEPTH));
    assign cpu_clamped = (i_in_item.cpu_load > CPU_MAX) ? CPU_MAX : i_in_item.cpu_load;
    assign old_mem     = r_rd_data[EW-1:CPU_W];
    assign old_cpu     = r_rd_data[CPU_W-1:0];

    // next pointer and count as left by the update step
    always_comb begin
        n_wp   = (r_wp == PW'(WINDOW_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        n_held = full ? r_held : r_held + 1'b1;
    end

    // slot read on accept, oldest read during the update
    always_comb begin
        mem_we  = i_cmd.update;
        mem_re  = i_cmd.latch | i_cmd.update;
        rd_addr = r_wp;
        if (i_cmd.update) begin
            rd_addr = (n_held == CW'(WINDOW_DEPTH)) ? n_wp : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_win[r_wp] <= {r_mem, r_cpu};
        end
        if (mem_re) begin
            r_rd_data <= r_win[rd_addr];
        end
    end

    // alert checks
    always_comb begin
        new_x20  = LEAK_W'({r_mem, 4'b0}) + LEAK_W'({r_mem, 2'b0});
        old_x21  = LEAK_W'({old_mem, 4'b0}) + LEAK_W'({old_mem, 2'b0}) + LEAK_W'(old_mem);
        leak_hit = (r_held >= CW'(LEAK_MIN_HELD)) && (old_mem != '0) && (new_x20 > old_x21);
        mem_hit  = (r_mem_lim != '0) &&
                   ((51'(r_mem) << 2) + 51'(r_mem) > (51'(r_mem_lim) << 2));
        hnd_hit  = (r_hnd_lim != '0) &&
                   ((19'(r_hnd) << 2) + 19'(r_hnd) > (19'(r_hnd_lim) << 2));
        hits      = 2'(leak_hit) + 2'(mem_hit) + 2'(hnd_hit);
        total_sum = {1'b0, r_total} + (TOTAL_W + 1)'(hits);
    end

    always_comb begin
        div_dividend = NW'(r_mem_sum);
        div_divisor  = DVW'(r_held);
        case (i_cmd.div_sel)
            DIV_CPU: div_dividend = NW'(r_cpu_sum);
            default: div_dividend = NW'(r_mem_sum);
        endcase
    end

    assign bdiv_start = i_cmd.div_start & (i_cmd.div_sel != DIV_LEAK);
    assign c5_start   = i_cmd.div_start & (i_cmd.div_sel == DIV_LEAK);

    ruam_div #(
        .NW  (NW),
        .DVW (DVW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (bdiv_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (bdiv_done),
        .o_quotient (div_quo)
    );

    // x/20 = (x/4)/5, one 16-bit digit of the quotient per cycle
    always_comb begin
        c5_part  = {r_c5_rem, r_c5_num[63:48]};
        c5_prod  = 38'(c5_part) * 38'(RECIP5);
        c5_digit = c5_prod[36:21];
        c5_rem   = 3'(c5_part - 19'(c5_digit) * 19'd5);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c5_cnt  <= '0;
            r_c5_done <= 1'b0;
        end else begin
            r_c5_done <= 1'b0;
            if (c5_start) begin
                r_c5_cnt <= 3'd4;
            end else if (r_c5_cnt != '0) begin
                r_c5_cnt  <= r_c5_cnt - 1'b1;
                r_c5_done <= (r_c5_cnt == 3'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c5_start) begin
            r_c5_num <= 64'(r_leak_prod >> 2);
            r_c5_rem <= '0;
            r_c5_quo <= '0;
        end else if (r_c5_cnt != '0) begin
            r_c5_num <= {r_c5_num[47:0], 16'd0};
            r_c5_rem <= c5_rem;
            r_c5_quo <= {r_c5_quo[47:0], c5_digit};
        end
    end

    assign div_done = bdiv_done | r_c5_done;

    assign out_take = r_out_valid & ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_held      <= '0;
            r_mem_sum   <= '0;
            r_cpu_sum   <= '0;
            r_peak_mem  <= '0;
            r_peak_cpu  <= '0;
            r_peak_hnd  <= '0;
            r_kind      <= KIND_NONE;
            r_aval      <= '0;
            r_alim      <= '0;
            r_total     <= '0;
            r_mem_lim   <= MEM_LIMIT_RST;
            r_hnd_lim   <= HND_LIMIT_RST;
            r_need_leak <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MEM_LIMIT: begin
                        if (i_cfg_data == '0 || i_cfg_data >= MEM_MIN_LIMIT) begin
                            r_mem_lim <= i_cfg_data;
                        end
                    end
                    CFG_HND_LIMIT: begin
                        if (i_cfg_data[HND_W-1:0] == '0 ||
                            i_cfg_data[HND_W-1:0] >= HND_MIN_LIMIT) begin
                            r_hnd_lim <= i_cfg_data[HND_W-1:0];
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.update) begin
                r_wp   <= n_wp;
                r_held <= n_held;
                if (full) begin
                    r_mem_sum <= r_mem_sum - SW'(old_mem) + SW'(r_mem);
                    r_cpu_sum <= r_cpu_sum - CSW'(old_cpu) + CSW'(r_cpu);
                end else begin
                    r_mem_sum <= r_mem_sum + SW'(r_mem);
                    r_cpu_sum <= r_cpu_sum + CSW'(r_cpu);
                end
                if (r_mem > r_peak_mem) r_peak_mem <= r_mem;
                if (r_cpu > r_peak_cpu) r_peak_cpu <= r_cpu;
                if (r_hnd > r_peak_hnd) r_peak_hnd <= r_hnd;
            end
            if (i_cmd.check) begin
                // handles alert wins over memory, memory over leak
                r_need_leak <= 1'b0;
                if (hnd_hit) begin
                    r_kind <= KIND_HANDLES;
                    r_aval <= MEM_W'(r_hnd);
                    r_alim <= LIMIT_W'(r_hnd_lim);
                end else if (mem_hit) begin
                    r_kind <= KIND_MEM;
                    r_aval <= r_mem;
                    r_alim <= LIMIT_W'(r_mem_lim);
                end else if (leak_hit) begin
                    r_kind      <= KIND_LEAK;
                    r_aval      <= r_mem;
                    r_need_leak <= 1'b1;
                end
                r_total <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
            end
            if (div_done && r_div_sel == DIV_LEAK) begin
                r_alim <= r_c5_quo[LIMIT_W-1:0];
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mem <= i_in_item.mem_used;
            r_cpu <= cpu_clamped;
            r_hnd <= i_in_item.handles_open;
        end
        if (i_cmd.check) begin
            r_leak_prod <= old_x21;
        end
        if (i_cmd.div_start) begin
            r_div_sel <= i_cmd.div_sel;
        end
        if (div_done && r_div_sel == DIV_MEM) begin
            r_mean_mem <= div_quo[MEM_W-1:0];
        end
        if (div_done && r_div_sel == DIV_CPU) begin
            r_mean_cpu <= div_quo[CPU_W-1:0];
        end
        if (i_cmd.emit) begin
            r_out.alert_kind   <= r_kind;
            r_out.alert_value  <= r_aval;
            r_out.alert_limit  <= r_alim;
            r_out.alert_total  <= r_total;
            r_out.peak_mem     <= r_peak_mem;
            r_out.peak_cpu     <= r_peak_cpu;
            r_out.peak_handles <= r_peak_hnd;
            r_out.samples_held <= HELD_W'(r_held);
            r_out.mean_mem     <= r_mean_mem;
            r_out.mean_cpu     <= r_mean_cpu;
        end
    end

    assign o_sts.div_done  = div_done;
    assign o_sts.need_leak = r_need_leak;
    assign o_sts.out_free  = ~r_out_valid | ~i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out_item      = r_out;

endmodule

/* hdl/ruam_ctrl.sv */
// sequencing state machine for the resource usage alert monitor
`include "resource_usage_alert_monitor_defines.svh"
module ruam_ctrl import ruam_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.div_sel   = DIV_MEM;
        o_in_stall      = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = S_START_MEM;
            end
            S_START_MEM: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_MEM;
                n_state         = S_WAIT_MEM;
            end
            S_WAIT_MEM: begin
                if (i_sts.div_done) n_state = S_START_CPU;
            end
            S_START_CPU: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_CPU;
                n_state         = S_WAIT_CPU;
            end
            S_WAIT_CPU: begin
                if (i_sts.div_done) begin
                    n_state = i_sts.need_leak ? S_START_LEAK : S_EMIT;
                end
            end
            S_START_LEAK: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_LEAK;
                n_state         = S_WAIT_LEAK;
            end
            S_WAIT_LEAK: begin
                if (i_sts.div_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `RUAM_ASSERT(a_emit_holds, i_clk, i_rst_n, (r_state == S_EMIT && !i_sts.out_free) |=> (r_state == S_EMIT), "result dropped while output busy")
    `RUAM_ASSERT(a_div_not_instant, i_clk, i_rst_n, o_cmd.div_start |=> !i_sts.div_done, "divider finished in one cycle")
    `RUAM_ASSERT(a_only_idle_takes, i_clk, i_rst_n, o_cmd.latch |-> (r_state == S_IDLE && !o_in_stall), "item taken outside idle")
    `RUAM_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE), "state not idle after reset")

endmodule

/* hdl/resource_usage_alert_monitor.sv */
// resource usage alert monitor top level
// one item at a time: accept, window update, checks, the two mean divisions and,
// when a leak sets the limit, the leak division, then the result; the bit-serial
// divider that forms both means is NW = 48+clog2(WINDOW_DEPTH+1) bits wide, so 56 at
// depth 128; a new item is taken once the previous result sits in the output
// register; synchronous active-low reset clears counts, sums, peaks, alert record
// and limits to their defaults; window contents are left as they are
module resource_usage_alert_monitor import ruam_pkg::*; #(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    // limit registers
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: accept, window update, checks, the two mean divisions, the leak division on a leak alert
    ruam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: window memory, running sums, peaks, alert record, dividers
    ruam_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
